### rtl/nrpp_pkg.sv
// Shared constants, codes and control types of the RMC position parser.
package nrpp_pkg;

    // Default sizes, handed to the top-level parameters.
    localparam int MAX_SENTENCE_DEF    = 82;
    localparam int MAX_COORD_CHARS_DEF = 14;

    // Fixed widths of the sentence bookkeeping.
    localparam int POS_W   = 7;
    localparam int LEN_W   = 4;
    localparam int FIELD_W = 4;
    localparam int CNT_W   = LEN_W + 1;

    // Characters that steer the parse.
    localparam logic [7:0] LINE_FEED  = 8'h0A;
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_WARN  = 8'h56;
    localparam logic [7:0] CHAR_NUL   = 8'h00;

    // Payload field numbers.
    localparam logic [FIELD_W-1:0] FIELD_STATUS    = 4'd1;
    localparam logic [FIELD_W-1:0] FIELD_LATITUDE  = 4'd2;
    localparam logic [FIELD_W-1:0] FIELD_LONGITUDE = 4'd4;
    localparam logic [FIELD_W-1:0] FIELD_SATURATED = 4'd15;

    // Header byte positions.
    localparam logic [POS_W-1:0] POS_TYPE_LAST = 7'd5;
    localparam logic [POS_W-1:0] POS_SKIP      = 7'd6;

    // Result item kinds.
    localparam logic [1:0] KIND_OUTCOME   = 2'd0;
    localparam logic [1:0] KIND_LATITUDE  = 2'd1;
    localparam logic [1:0] KIND_LONGITUDE = 2'd2;

    // Sentence outcome codes.
    localparam logic [1:0] OC_OK       = 2'd0;
    localparam logic [1:0] OC_NO_DOLLAR = 2'd1;
    localparam logic [1:0] OC_REJECT   = 2'd2;
    localparam logic [1:0] OC_OVERFLOW = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;     // take the input byte
        logic load_next;  // load the next coordinate character into the output
    } nrpp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic emit;       // the presented byte produces results
        logic last;       // the item in the output register is the final one
    } nrpp_status_t;

    // Expected sentence type character at header positions 1 to 5.
    function automatic logic [7:0] type_char(input logic [POS_W-1:0] pos);
        logic [7:0] ch;
        case (pos)
            7'd1:    ch = 8'h47;  // G
            7'd2:    ch = 8'h50;  // P
            7'd3:    ch = 8'h52;  // R
            7'd4:    ch = 8'h4D;  // M
            7'd5:    ch = 8'h43;  // C
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

### rtl/nrpp_ctrl.sv
// Controller state machine that sequences byte intake and result delivery.
module nrpp_ctrl
    import nrpp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    output logic         m_valid,
    input  logic         m_ready,
    input  nrpp_status_t status,
    output nrpp_cmd_t    cmd
);

    localparam logic [0:0] ST_IDLE = 1'b0;
    localparam logic [0:0] ST_SEND = 1'b1;

    logic [0:0] state_reg;
    logic [0:0] state_next;

    // Next state and command decode.
    always_comb begin
        state_next    = state_reg;
        cmd.accept    = 1'b0;
        cmd.load_next = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    if (status.emit) begin
                        state_next = ST_SEND;
                    end
                end
            end
            ST_SEND: begin
                if (m_ready) begin
                    if (status.last) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.load_next = 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_SEND);

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/nrpp_datapath.sv
// Datapath: sentence parse state, coordinate banks and the output register.
module nrpp_datapath
    import nrpp_pkg::*;
#(
    parameter int MAX_SENTENCE    = MAX_SENTENCE_DEF,
    parameter int MAX_COORD_CHARS = MAX_COORD_CHARS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic [7:0]   rx_byte,
    input  nrpp_cmd_t    cmd,
    output nrpp_status_t status,
    output logic [1:0]   item_kind,
    output logic [1:0]   outcome,
    output logic [7:0]   char_value,
    output logic         last
);

    localparam int IDX_W = (MAX_COORD_CHARS > 1) ? $clog2(MAX_COORD_CHARS) : 1;

    // Sentence state.
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               header_ok_reg, header_ok_next;
    logic [FIELD_W-1:0] field_reg, field_next;
    logic               warn_reg, warn_next;
    logic               fstart_reg, fstart_next;
    logic [LEN_W-1:0]   lat_len_reg, lat_len_next;
    logic [LEN_W-1:0]   lon_len_reg, lon_len_next;
    logic               lat_seen_reg, lat_seen_next;
    logic               lon_seen_reg, lon_seen_next;

    // Committed position: length and bank select per coordinate.
    logic [LEN_W-1:0]   slat_len_reg, slat_len_next;
    logic [LEN_W-1:0]   slon_len_reg, slon_len_next;
    logic               lat_sel_reg, lat_sel_next;
    logic               lon_sel_reg, lon_sel_next;

    // Two banks per coordinate: one committed, the other being filled.
    logic [7:0] lat_mem_reg [2][MAX_COORD_CHARS];
    logic [7:0] lon_mem_reg [2][MAX_COORD_CHARS];
    logic       lat_wr, lon_wr;

    // Result delivery.
    logic [CNT_W-1:0] emit_cnt_reg, emit_cnt_next;
    logic [1:0]       kind_reg, kind_next;
    logic [1:0]       oc_reg, oc_next;
    logic [7:0]       char_reg, char_next;
    logic             last_reg, last_next;

    logic             is_lf, is_ovf;
    logic [CNT_W-1:0] total, lon_off, cnt_inc;
    logic             in_lat;
    logic [1:0]       lf_oc;
    logic [LEN_W-1:0] new_slat, new_slon;

    assign is_lf  = (rx_byte == LINE_FEED);
    assign is_ovf = !is_lf && (pos_reg >= POS_W'(MAX_SENTENCE));

    assign status.emit = is_lf || is_ovf;
    assign status.last = last_reg;

    // Character sequencing over the committed banks.
    assign total   = CNT_W'(slat_len_reg) + CNT_W'(slon_len_reg);
    assign in_lat  = (emit_cnt_reg < CNT_W'(slat_len_reg));
    assign lon_off = emit_cnt_reg - CNT_W'(slat_len_reg);
    assign cnt_inc = emit_cnt_reg + CNT_W'(1);

    // Line feed outcome and the lengths it commits.
    always_comb begin
        if (pos_reg == '0 || !header_ok_reg) begin
            lf_oc = OC_NO_DOLLAR;
        end else if (pos_reg < POS_SKIP || warn_reg) begin
            lf_oc = OC_REJECT;
        end else begin
            lf_oc = OC_OK;
        end
        new_slat = (lf_oc == OC_OK && lat_seen_reg) ? lat_len_reg : slat_len_reg;
        new_slon = (lf_oc == OC_OK && lon_seen_reg) ? lon_len_reg : slon_len_reg;
    end

    // Parse and delivery next-state logic.
    always_comb begin
        pos_next       = pos_reg;
        header_ok_next = header_ok_reg;
        field_next     = field_reg;
        warn_next      = warn_reg;
        fstart_next    = fstart_reg;
        lat_len_next   = lat_len_reg;
        lon_len_next   = lon_len_reg;
        lat_seen_next  = lat_seen_reg;
        lon_seen_next  = lon_seen_reg;
        slat_len_next  = slat_len_reg;
        slon_len_next  = slon_len_reg;
        lat_sel_next   = lat_sel_reg;
        lon_sel_next   = lon_sel_reg;
        emit_cnt_next  = emit_cnt_reg;
        kind_next      = kind_reg;
        oc_next        = oc_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        lat_wr         = 1'b0;
        lon_wr         = 1'b0;

        if (cmd.accept) begin
            if (is_lf || is_ovf) begin
                // Sentence ends: present the outcome item and start over.
                pos_next       = '0;
                header_ok_next = 1'b1;
                field_next     = '0;
                warn_next      = 1'b0;
                fstart_next    = 1'b0;
                lat_len_next   = '0;
                lon_len_next   = '0;
                lat_seen_next  = 1'b0;
                lon_seen_next  = 1'b0;
                emit_cnt_next  = '0;
                kind_next      = KIND_OUTCOME;
                char_next      = CHAR_NUL;
                if (is_lf) begin
                    oc_next = lf_oc;
                    last_next = (lf_oc != OC_OK) ||
                                (new_slat == '0 && new_slon == '0);
                    if (lf_oc == OC_OK && lat_seen_reg) begin
                        slat_len_next = lat_len_reg;
                        lat_sel_next  = !lat_sel_reg;
                    end
                    if (lf_oc == OC_OK && lon_seen_reg) begin
                        slon_len_next = lon_len_reg;
                        lon_sel_next  = !lon_sel_reg;
                    end
                end else begin
                    oc_next   = OC_OVERFLOW;
                    last_next = 1'b1;
                end
            end else begin
                // Header checks, then payload field parsing.
                pos_next = pos_reg + POS_W'(1);
                if (pos_reg == '0) begin
                    if (rx_byte != CHAR_DOLLAR) begin
                        header_ok_next = 1'b0;
                    end
                end else if (pos_reg <= POS_TYPE_LAST) begin
                    if (rx_byte != type_char(pos_reg)) begin
                        warn_next = 1'b1;
                    end
                end else if (pos_reg == POS_SKIP) begin
                    fstart_next = 1'b1;
                end else if (header_ok_reg && !warn_reg) begin
                    if (rx_byte == CHAR_NUL) begin
                        field_next  = FIELD_SATURATED;
                        fstart_next = 1'b0;
                    end else if (field_reg != FIELD_SATURATED) begin
                        if (rx_byte == CHAR_COMMA) begin
                            field_next  = field_reg + FIELD_W'(1);
                            fstart_next = 1'b1;
                            if (field_next == FIELD_LATITUDE) begin
                                lat_seen_next = 1'b1;
                            end
                            if (field_next == FIELD_LONGITUDE) begin
                                lon_seen_next = 1'b1;
                            end
                        end else begin
                            fstart_next = 1'b0;
                            if (field_reg == FIELD_STATUS && fstart_reg &&
                                rx_byte == CHAR_WARN) begin
                                warn_next = 1'b1;
                            end else if (field_reg == FIELD_LATITUDE) begin
                                if (lat_len_reg < LEN_W'(MAX_COORD_CHARS)) begin
                                    lat_wr       = 1'b1;
                                    lat_len_next = lat_len_reg + LEN_W'(1);
                                end
                            end else if (field_reg == FIELD_LONGITUDE) begin
                                if (lon_len_reg < LEN_W'(MAX_COORD_CHARS)) begin
                                    lon_wr       = 1'b1;
                                    lon_len_next = lon_len_reg + LEN_W'(1);
                                end
                            end
                        end
                    end
                end
            end
        end

        // Next coordinate character into the output register.
        if (cmd.load_next) begin
            oc_next       = OC_OK;
            emit_cnt_next = cnt_inc;
            last_next     = (cnt_inc == total);
            if (in_lat) begin
                kind_next = KIND_LATITUDE;
                char_next = lat_mem_reg[lat_sel_reg][emit_cnt_reg[IDX_W-1:0]];
            end else begin
                kind_next = KIND_LONGITUDE;
                char_next = lon_mem_reg[lon_sel_reg][lon_off[IDX_W-1:0]];
            end
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            header_ok_reg <= 1'b1;
            field_reg     <= '0;
            warn_reg      <= 1'b0;
            fstart_reg    <= 1'b0;
            lat_len_reg   <= '0;
            lon_len_reg   <= '0;
            lat_seen_reg  <= 1'b0;
            lon_seen_reg  <= 1'b0;
            slat_len_reg  <= '0;
            slon_len_reg  <= '0;
            lat_sel_reg   <= 1'b0;
            lon_sel_reg   <= 1'b0;
            emit_cnt_reg  <= '0;
            last_reg      <= 1'b1;
        end else begin
            pos_reg       <= pos_next;
            header_ok_reg <= header_ok_next;
            field_reg     <= field_next;
            warn_reg      <= warn_next;
            fstart_reg    <= fstart_next;
            lat_len_reg   <= lat_len_next;
            lon_len_reg   <= lon_len_next;
            lat_seen_reg  <= lat_seen_next;
            lon_seen_reg  <= lon_seen_next;
            slat_len_reg  <= slat_len_next;
            slon_len_reg  <= slon_len_next;
            lat_sel_reg   <= lat_sel_next;
            lon_sel_reg   <= lon_sel_next;
            emit_cnt_reg  <= emit_cnt_next;
            last_reg      <= last_next;
        end
    end

    // Payload registers: output item and coordinate character banks.
    always_ff @(posedge aclk) begin
        kind_reg <= kind_next;
        oc_reg   <= oc_next;
        char_reg <= char_next;
        if (lat_wr) begin
            lat_mem_reg[!lat_sel_reg][lat_len_reg[IDX_W-1:0]] <= rx_byte;
        end
        if (lon_wr) begin
            lon_mem_reg[!lon_sel_reg][lon_len_reg[IDX_W-1:0]] <= rx_byte;
        end
    end

    assign item_kind  = kind_reg;
    assign outcome    = oc_reg;
    assign char_value = char_reg;
    assign last       = last_reg;

endmodule

### rtl/nmea_rmc_position_parser.sv
// Top level of the RMC position parser: controller plus datapath.
//
// The s_ channel takes one received byte per request (s_rx_byte). Bytes that do
// not end a sentence are absorbed with no result in the cycle they are accepted,
// and s_ready stays high, so one byte is taken per cycle while no results are
// pending.
// A line feed, or a byte that overruns the sentence limit, produces results on
// the m_ channel: an outcome request first, then on success the committed
// latitude characters and then the longitude characters, with m_last on the
// final one. The first result is valid in the cycle after the byte is accepted,
// and each further result follows in the cycle after the previous one is taken.
// A burst thus holds the input until its last result request is taken;
// the single output register sets this.
// While m_ready is low the current result holds and s_ready stays low.
// Reset (aresetn low, synchronous) clears the sentence state and the committed
// position lengths; no result is pending afterward.
module nmea_rmc_position_parser
    import nrpp_pkg::*;
#(
    parameter int MAX_SENTENCE    = MAX_SENTENCE_DEF,
    parameter int MAX_COORD_CHARS = MAX_COORD_CHARS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_item_kind,
    output logic [1:0] m_outcome,
    output logic [7:0] m_char_value,
    output logic       m_last
);

    nrpp_cmd_t    cmd;
    nrpp_status_t status;

    // Sequencing of intake and delivery.
    nrpp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Parsing state, coordinate storage and the output register.
    nrpp_datapath #(
        .MAX_SENTENCE    (MAX_SENTENCE),
        .MAX_COORD_CHARS (MAX_COORD_CHARS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .rx_byte    (s_rx_byte),
        .cmd        (cmd),
        .status     (status),
        .item_kind  (m_item_kind),
        .outcome    (m_outcome),
        .char_value (m_char_value),
        .last       (m_last)
    );

endmodule

### test/nmea_rmc_position_parser_tb.sv
// Self-checking testbench for the RMC position parser: directed sentences, then random traffic.
module nmea_rmc_position_parser_tb
    import nrpp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Run limits and the long receiver hold-off.
    localparam int HOLD_OFF_CYCLES  = 400;
    localparam int DRAIN_CYCLES     = 40;
    localparam int RANDOM_MIN_BYTES = 30;
    localparam int RANDOM_MIN_LINES = 1;
    localparam int NO_TYPED_OUTCOME = -1;
    localparam string RMC_TYPE      = "GPRMC";

    // One result request as the block presents it.
    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] oc;
        logic [7:0] ch;
        logic       last;
    } parse_result_t;

    // One directed sentence: text, optional zero byte, fill length and typed outcome.
    typedef struct {
        string text;
        int    nul_at;
        int    fill_to;
        int    typed_oc;
    } sentence_row_t;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    logic [7:0] s_rx_byte = 8'h00;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    logic [1:0] m_item_kind;
    logic [1:0] m_outcome;
    logic [7:0] m_char_value;
    logic       m_last;

    parse_result_t pending_results[$];
    logic [7:0]    sentence_bytes[$];
    sentence_row_t directed_rows[$];
    int            fault_count       = 0;
    bit            quiet_run         = 1'b0;
    bit            long_hold_pending = 1'b0;

    // Predictor copy of the parser state.
    logic [POS_W-1:0]   pos;
    logic               hdr_good;
    logic [FIELD_W-1:0] field_idx;
    logic               warned;
    logic               at_field_start;
    logic [7:0]         lat_buf [MAX_COORD_CHARS_DEF];
    logic [7:0]         lon_buf [MAX_COORD_CHARS_DEF];
    logic [7:0]         lat_store [MAX_COORD_CHARS_DEF];
    logic [7:0]         lon_store [MAX_COORD_CHARS_DEF];
    logic [LEN_W-1:0]   lat_len, lon_len, lat_store_len, lon_store_len;
    logic               lat_seen, lon_seen;

    nmea_rmc_position_parser u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_rx_byte    (s_rx_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_item_kind  (m_item_kind),
        .m_outcome    (m_outcome),
        .m_char_value (m_char_value),
        .m_last       (m_last)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Drop the sentence in progress; committed positions stay.
    function automatic void sentence_restart();
        pos            = '0;
        hdr_good       = 1'b1;
        field_idx      = '0;
        warned         = 1'b0;
        at_field_start = 1'b0;
        lat_len        = '0;
        lon_len        = '0;
        lat_seen       = 1'b0;
        lon_seen       = 1'b0;
    endfunction

    // One payload byte: field counting, warning status and coordinate capture.
    function automatic void take_payload(input logic [7:0] b);
        if (b == CHAR_NUL) begin
            field_idx      = FIELD_SATURATED;
            at_field_start = 1'b0;
        end else if (field_idx != FIELD_SATURATED) begin
            if (b == CHAR_COMMA) begin
                field_idx      = field_idx + 1'b1;
                at_field_start = 1'b1;
                if (field_idx == FIELD_LATITUDE) lat_seen = 1'b1;
                if (field_idx == FIELD_LONGITUDE) lon_seen = 1'b1;
            end else begin
                if (field_idx == FIELD_STATUS && at_field_start && b == CHAR_WARN) begin
                    warned = 1'b1;
                end else if (field_idx == FIELD_LATITUDE) begin
                    if (lat_len < MAX_COORD_CHARS_DEF) begin
                        lat_buf[lat_len] = b;
                        lat_len = lat_len + 1'b1;
                    end
                end else if (field_idx == FIELD_LONGITUDE) begin
                    if (lon_len < MAX_COORD_CHARS_DEF) begin
                        lon_buf[lon_len] = b;
                        lon_len = lon_len + 1'b1;
                    end
                end
                at_field_start = 1'b0;
            end
        end
    endfunction

    // Advance the parser by one accepted byte and queue the results it causes.
    // A typed outcome, where given, replaces the predicted outcome of a line feed.
    function automatic void predict_byte(input logic [7:0] b, input int typed_oc);
        parse_result_t burst[$];
        logic [1:0]    oc;
        int            i;
        if (b == LINE_FEED) begin
            if (pos == 0 || !hdr_good) oc = OC_NO_DOLLAR;
            else if (pos < POS_SKIP || warned) oc = OC_REJECT;
            else oc = OC_OK;
            burst.push_back('{KIND_OUTCOME, oc, 8'h00, 1'b0});
            if (oc == OC_OK) begin
                if (lat_seen) begin
                    for (i = 0; i < int'(lat_len); i++) lat_store[i] = lat_buf[i];
                    lat_store_len = lat_len;
                end
                if (lon_seen) begin
                    for (i = 0; i < int'(lon_len); i++) lon_store[i] = lon_buf[i];
                    lon_store_len = lon_len;
                end
                for (i = 0; i < int'(lat_store_len); i++)
                    burst.push_back('{KIND_LATITUDE, OC_OK, lat_store[i], 1'b0});
                for (i = 0; i < int'(lon_store_len); i++)
                    burst.push_back('{KIND_LONGITUDE, OC_OK, lon_store[i], 1'b0});
            end
            sentence_restart();
            if (typed_oc != NO_TYPED_OUTCOME) burst[0].oc = typed_oc[1:0];
        end else if (pos >= MAX_SENTENCE_DEF) begin
            // Overrun: the byte is dropped and the sentence starts over.
            sentence_restart();
            burst.push_back('{KIND_OUTCOME, OC_OVERFLOW, 8'h00, 1'b0});
        end else begin
            if (pos == 0) begin
                if (b != CHAR_DOLLAR) hdr_good = 1'b0;
            end else if (pos <= POS_TYPE_LAST) begin
                if (b != RMC_TYPE[pos - 1]) warned = 1'b1;
            end else if (pos == POS_SKIP) begin
                at_field_start = 1'b1;
            end else if (hdr_good && !warned) begin
                take_payload(b);
            end
            pos = pos + 1'b1;
        end
        if (burst.size() > 0) begin
            burst[burst.size() - 1].last = 1'b1;
            foreach (burst[i]) pending_results.push_back(burst[i]);
        end
    endfunction

    // Offer one byte after a random gap and wait for the block to take it.
    task automatic send_byte(input logic [7:0] b, input int typed_oc);
        int gap;
        gap = quiet_run ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        predict_byte(b, typed_oc);
    endtask

    // Send the bytes of the current sentence; only its line feed carries a typed outcome.
    task automatic send_sentence(input int typed_oc);
        int i;
        for (i = 0; i < sentence_bytes.size(); i++)
            send_byte(sentence_bytes[i], (i == sentence_bytes.size() - 1) ? typed_oc
                                                                          : NO_TYPED_OUTCOME);
    endtask

    function automatic void append_text(input string text);
        int i;
        for (i = 0; i < text.len(); i++) sentence_bytes.push_back(text[i]);
    endfunction

    function automatic logic [7:0] rand_byte_except_lf();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == LINE_FEED) b = 8'h8A;
        return b;
    endfunction

    // A coordinate character: mostly digits and dots, sometimes any plain byte.
    function automatic logic [7:0] coord_char();
        logic [7:0] b;
        if ($urandom_range(0, 3) == 0) begin
            b = rand_byte_except_lf();
            if (b == CHAR_COMMA || b == CHAR_NUL) b = 8'hC5;
        end else if ($urandom_range(0, 9) == 0) begin
            b = ".";
        end else begin
            b = 8'("0" + $urandom_range(0, 9));
        end
        return b;
    endfunction

    function automatic void append_coord(input int len);
        repeat (len) sentence_bytes.push_back(coord_char());
    endfunction

    function automatic int coord_length();
        return ($urandom_range(0, 7) == 0) ? $urandom_range(12, 18) : $urandom_range(0, 9);
    endfunction

    // Random sentence: mostly well formed with random content, the rest noise,
    // overlong lines and broken headers. Always ends with a line feed.
    function automatic void build_random_sentence();
        int shape, n, cut;
        sentence_bytes.delete();
        shape = $urandom_range(0, 99);
        if (shape < 65) begin
            append_text("$GPRMC");
            sentence_bytes.push_back(($urandom_range(0, 9) == 0) ? rand_byte_except_lf()
                                                                 : CHAR_COMMA);
            append_coord($urandom_range(0, 6));
            sentence_bytes.push_back(CHAR_COMMA);
            n = $urandom_range(0, 19);
            if (n < 2) sentence_bytes.push_back(CHAR_WARN);
            else if (n < 3) sentence_bytes.push_back(coord_char());
            else if (n > 3) sentence_bytes.push_back("A");
            if ($urandom_range(0, 5) == 0) sentence_bytes.push_back(coord_char());
            sentence_bytes.push_back(CHAR_COMMA);
            append_coord(coord_length());
            sentence_bytes.push_back(CHAR_COMMA);
            sentence_bytes.push_back($urandom_range(0, 1) ? "N" : "S");
            sentence_bytes.push_back(CHAR_COMMA);
            append_coord(coord_length());
            sentence_bytes.push_back(CHAR_COMMA);
            sentence_bytes.push_back($urandom_range(0, 1) ? "E" : "W");
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 14)) begin
                    sentence_bytes.push_back(CHAR_COMMA);
                    append_coord($urandom_range(0, 3));
                end
            end
            // Occasional damage: a zero byte, a bad header byte, or a cut line.
            if ($urandom_range(0, 11) == 0)
                sentence_bytes[$urandom_range(7, sentence_bytes.size() - 1)] = CHAR_NUL;
            if ($urandom_range(0, 11) == 0)
                sentence_bytes[$urandom_range(0, 5)] = rand_byte_except_lf();
            if ($urandom_range(0, 9) == 0) begin
                cut = $urandom_range(0, sentence_bytes.size() - 1);
                while (sentence_bytes.size() > cut) void'(sentence_bytes.pop_back());
            end
        end else if (shape < 80) begin
            repeat ($urandom_range(0, 24)) sentence_bytes.push_back(8'($urandom_range(0, 255)));
        end else if (shape < 90) begin
            append_text("$GPRMC,");
            n = $urandom_range(80, 100);
            while (sentence_bytes.size() < n) sentence_bytes.push_back(rand_byte_except_lf());
        end else begin
            append_text("$GPRMC");
            cut = $urandom_range(1, 6);
            while (sentence_bytes.size() > cut) void'(sentence_bytes.pop_back());
            if ($urandom_range(0, 1))
                sentence_bytes[$urandom_range(0, cut - 1)] = rand_byte_except_lf();
        end
        sentence_bytes.push_back(LINE_FEED);
    endfunction

    function automatic void add_row(input string text, input int nul_at, input int fill_to,
                                    input int typed_oc);
        sentence_row_t row;
        row.text     = text;
        row.nul_at   = nul_at;
        row.fill_to  = fill_to;
        row.typed_oc = typed_oc;
        directed_rows.push_back(row);
    endfunction

    // Result sink: random stalls per request, one long hold-off on demand.
    initial begin : result_sink
        int stall;
        wait (aresetn);
        forever begin
            if (long_hold_pending) begin
                long_hold_pending = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end
            stall = quiet_run ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Compare every accepted result with the oldest expectation.
    always @(posedge aclk) begin : result_check
        parse_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: kind %0d outcome %0d char %02h last %0d",
                       m_item_kind, m_outcome, m_char_value, m_last);
                fault_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_item_kind !== want.kind) begin
                    $error("m_item_kind: expected %0d, got %0d", want.kind, m_item_kind);
                    fault_count++;
                end
                if (m_outcome !== want.oc) begin
                    $error("m_outcome: expected %0d, got %0d", want.oc, m_outcome);
                    fault_count++;
                end
                if (m_char_value !== want.ch) begin
                    $error("m_char_value: expected %02h, got %02h", want.ch, m_char_value);
                    fault_count++;
                end
                if (m_last !== want.last) begin
                    $error("m_last: expected %0d, got %0d", want.last, m_last);
                    fault_count++;
                end
            end
        end
    end

    // Hard stop in case the block hangs.
    initial begin
        #1_000_000;
        $display("nmea_rmc_position_parser test failed");
        $finish;
    end

    initial begin : stimulus
        int random_bytes, random_lines;
        lat_store_len = '0;
        lon_store_len = '0;
        sentence_restart();

        // Directed sentences; outcomes typed where they are obvious.
        add_row("", -1, 0, OC_NO_DOLLAR);
        add_row("$GPRMC", -1, 0, OC_OK);
        add_row("$GP", -1, 0, OC_REJECT);
        add_row("$GPGGA", -1, 0, OC_REJECT);
        add_row("GPRMC,1", -1, 0, OC_NO_DOLLAR);
        add_row("$GPRMC,1,V,48,N,11,E", -1, 0, OC_REJECT);
        add_row("$GPRMC,1,AV,123456789012345,S,1234567890123456,W",
                -1, 0, NO_TYPED_OUTCOME);
        add_row("$GPRMC,1,A,55", -1, 0, NO_TYPED_OUTCOME);
        add_row("$GPRMC,1,A,,N", -1, 0, NO_TYPED_OUTCOME);
        add_row("$GPRMC,a,b,c,d,e,f,g,h,i,j,k,l,m,n,o,p,q,r,s,t", -1, 0, NO_TYPED_OUTCOME);
        add_row("$GPRMC,1,A,12x34,N,567", 13, 0, NO_TYPED_OUTCOME);
        add_row("$GPRMC,1,A,4", -1, 83, NO_TYPED_OUTCOME);
        add_row("$GPRMCX\377,A,\377\001,N,\200", -1, 0, NO_TYPED_OUTCOME);
        add_row("$GPRMC", -1, 0, NO_TYPED_OUTCOME);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // The receiver holds off once right at the start so the block backs up.
        long_hold_pending = 1'b1;
        foreach (directed_rows[r]) begin
            sentence_bytes.delete();
            append_text(directed_rows[r].text);
            if (directed_rows[r].nul_at >= 0) sentence_bytes[directed_rows[r].nul_at] = CHAR_NUL;
            while (sentence_bytes.size() < directed_rows[r].fill_to) sentence_bytes.push_back("7");
            sentence_bytes.push_back(LINE_FEED);
            send_sentence(directed_rows[r].typed_oc);
        end

        // Random traffic.
        random_bytes = 0;
        random_lines = 0;
        while (random_bytes < RANDOM_MIN_BYTES || random_lines < RANDOM_MIN_LINES) begin
            quiet_run = ($urandom_range(0, 4) == 0);
            build_random_sentence();
            random_bytes += sentence_bytes.size();
            random_lines++;
            send_sentence(NO_TYPED_OUTCOME);
        end
        quiet_run = 1'b0;
        s_valid <= 1'b0;

        // Drain, then give any stray result time to show up.
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fault_count == 0)
            $display("nmea_rmc_position_parser test passed");
        else
            $display("nmea_rmc_position_parser test failed");
        $finish;
    end

endmodule
